>>> rtl/npir_pkg.sv
// ----------------------------------------------------------------------------
// npir_pkg
// Shared types and constants for the nearest-point-in-radius search block:
// command and response beat layouts, mode codes and parameter defaults.
// ----------------------------------------------------------------------------
package npir_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 16;
  localparam int DIST_W   = 34;

  // Number of table entries that the slot field can reach.
  localparam int SLOT_RANGE = 1 << SLOT_W;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_USE   = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [RADIUS_W-1:0]        trigger_radius;
    logic                       single_use;
    logic                       gate_open;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [DIST_W-1:0] hit_dist_sq;
    logic              gated;
  } rsp_t;

endpackage

>>> rtl/nearest_point_in_radius_core.sv
// Query and use beats: idle accepts the command beat, the scan state reads the point
// table one entry per cycle through a four-stage distance pipeline (DEPTH entries,
// DEPTH = MAX_POINTS capped at 64), drain waits for the pipeline to empty, and finish
// loads the response register once it is free; idle then takes the next command. Load
// and unknown beats go from idle straight to finish. Reset clears the valid and used
// flags at once, with no clearing pass; the point table is undefined until loaded.
// ----------------------------------------------------------------------------
// nearest_point_in_radius_core
// Point table with per-entry trigger radius and one-shot marking. Query and
// use beats scan the table for the nearest in-range entry; use beats may mark
// a one-shot entry as used.
// ----------------------------------------------------------------------------
module nearest_point_in_radius_core #(
  parameter int MAX_POINTS = npir_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = npir_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  npir_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output npir_pkg::rsp_t rsp
);
  import npir_pkg::*;

  localparam int DEPTH = (MAX_POINTS < SLOT_RANGE) ? MAX_POINTS : SLOT_RANGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CB    = COORD_BITS;
  localparam int SQW   = 2 * CB;
  localparam int DW    = SQW + 2;
  localparam int R2W   = 2 * RADIUS_W;
  localparam int CMPW  = (DW > R2W) ? DW : R2W;

  typedef struct packed {
    logic [CB-1:0]       x;
    logic [CB-1:0]       y;
    logic [CB-1:0]       z;
    logic [RADIUS_W-1:0] radius;
    logic                once;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
    logic signed [CB:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    abs_diff = d[CB] ? CB'(-d) : CB'(d);
  endfunction

  state_t            state;
  logic [AW-1:0]     idx;
  logic [MODE_W-1:0] op_mode;
  logic              gate;
  logic [CB-1:0]     ex, ey, ez;
  logic              found;
  logic [DW-1:0]     best;
  logic [AW-1:0]     best_slot;
  logic              best_once;
  logic [DEPTH-1:0]  valid_bits;
  logic [DEPTH-1:0]  used_bits;

  entry_t            mem [DEPTH];
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              mem_we;
  logic              load_ok;
  logic [AW-1:0]     slot_a;
  logic [CB-1:0]     cx_in, cy_in, cz_in;

  // Distance pipeline.
  logic              s1_v, s2_v, s3_v, s4_v;
  logic [AW-1:0]     s1_slot, s2_slot, s3_slot, s4_slot;
  logic              s1_valid_bit, s1_used;
  logic [CB-1:0]     s2_ax, s2_ay, s2_az;
  logic [RADIUS_W-1:0] s2_rad;
  logic              s2_ok, s3_ok, s4_ok;
  logic              s2_once, s3_once, s4_once;
  logic [SQW-1:0]    s3_sqx, s3_sqy, s3_sqz;
  logic [R2W-1:0]    s3_r2, s4_r2;
  logic [DW-1:0]     s4_d2;
  logic              s4_take;

  // If COORD_BITS <= COORD_W the low COORD_BITS bits are taken as two's complement; else zero-extended.
  if (CB <= COORD_W) begin : g_coord_trunc
    assign cx_in = cmd.coord_x[CB-1:0];
    assign cy_in = cmd.coord_y[CB-1:0];
    assign cz_in = cmd.coord_z[CB-1:0];
  end else begin : g_coord_ext
    assign cx_in = {{(CB-COORD_W){1'b0}}, cmd.coord_x};
    assign cy_in = {{(CB-COORD_W){1'b0}}, cmd.coord_y};
    assign cz_in = {{(CB-COORD_W){1'b0}}, cmd.coord_z};
  end

  assign cmd_ready = (state == S_IDLE);
  assign load_ok   = int'(cmd.slot) < DEPTH;
  assign slot_a    = cmd.slot[AW-1:0];
  assign mem_we    = cmd_valid && cmd_ready && (cmd.mode == MODE_LOAD) && load_ok;

  always_comb begin
    wr_entry.x      = cx_in;
    wr_entry.y      = cy_in;
    wr_entry.z      = cz_in;
    wr_entry.radius = cmd.trigger_radius;
    wr_entry.once   = cmd.single_use;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_a] <= wr_entry;
    end
    rd_entry <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= (state == S_SCAN);
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot      <= idx;
    s1_valid_bit <= valid_bits[idx];
    s1_used      <= used_bits[idx];

    s2_ax   <= abs_diff(ex, rd_entry.x);
    s2_ay   <= abs_diff(ey, rd_entry.y);
    s2_az   <= abs_diff(ez, rd_entry.z);
    s2_rad  <= rd_entry.radius;
    s2_ok   <= s1_valid_bit && !(rd_entry.once && s1_used);
    s2_once <= rd_entry.once;
    s2_slot <= s1_slot;

    s3_sqx  <= s2_ax * s2_ax;
    s3_sqy  <= s2_ay * s2_ay;
    s3_sqz  <= s2_az * s2_az;
    s3_r2   <= s2_rad * s2_rad;
    s3_ok   <= s2_ok;
    s3_once <= s2_once;
    s3_slot <= s2_slot;

    s4_d2   <= DW'(s3_sqx) + DW'(s3_sqy) + DW'(s3_sqz);
    s4_r2   <= s3_r2;
    s4_ok   <= s3_ok;
    s4_once <= s3_once;
    s4_slot <= s3_slot;
  end

  // Entries arrive in ascending slot order, so a strict compare keeps the
  // lower slot on a tie.
  assign s4_take = s4_v && s4_ok && (CMPW'(s4_d2) <= CMPW'(s4_r2))
                   && (!found || (s4_d2 < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      rsp_valid  <= 1'b0;
      found      <= 1'b0;
      valid_bits <= '0;
      used_bits  <= '0;
    end else begin
      // In the finish state the response register is loaded below instead.
      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_mode <= cmd.mode;
            gate    <= cmd.gate_open;
            ex      <= cx_in;
            ey      <= cy_in;
            ez      <= cz_in;
            found   <= 1'b0;
            idx     <= '0;
            if ((cmd.mode == MODE_QUERY) || (cmd.mode == MODE_USE)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
              if (mem_we) begin
                valid_bits[slot_a] <= 1'b1;
                used_bits[slot_a]  <= 1'b0;
              end
            end
          end
        end
        S_SCAN: begin
          idx <= idx + AW'(1);
          if (idx == AW'(DEPTH - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!(s1_v || s2_v || s3_v || s4_v)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.hit         <= found;
            rsp.hit_slot    <= found ? SLOT_W'(best_slot) : '0;
            rsp.hit_dist_sq <= found ? DIST_W'(best) : '0;
            rsp.gated       <= found && (op_mode == MODE_USE) && !gate;
            if (found && (op_mode == MODE_USE) && gate && best_once) begin
              used_bits[best_slot] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (s4_take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_take) begin
      best      <= s4_d2;
      best_slot <= s4_slot;
      best_once <= s4_once;
    end
  end

  a_gated_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.gated || rsp.hit))
    else $error("gated response without a hit");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> ((rsp.hit_slot == '0) && (rsp.hit_dist_sq == '0)))
    else $error("miss response carries a slot or distance");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while another is in flight");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(s1_v || s2_v || s3_v || s4_v))
    else $error("distance pipeline busy while idle");

endmodule

>>> tb/tb_nearest_point_in_radius_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_point_in_radius_core
// Self-checking bench for the nearest-point-in-radius search block. A queued
// driver feeds load, query, use and unknown beats under random back-pressure.
// A model of the point table predicts every response beat, and the monitor
// checks each response field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_nearest_point_in_radius_core;
  import npir_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int NUM_RANDOM  = 600;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  cmd_t pending[$];
  rsp_t expected_rsp[$];
  int   errors = 0;
  int   cycles = 0;
  int   n_accepted = 0;
  int   n_loads = 0, n_searches = 0, n_hits = 0, n_gated = 0, n_unknown = 0;

  // Scoreboard copy of the point table.
  logic signed [COORD_W-1:0] tbl_x[SLOT_RANGE];
  logic signed [COORD_W-1:0] tbl_y[SLOT_RANGE];
  logic signed [COORD_W-1:0] tbl_z[SLOT_RANGE];
  logic [RADIUS_W-1:0]       tbl_r[SLOT_RANGE];
  logic                      tbl_once[SLOT_RANGE];
  logic                      tbl_used[SLOT_RANGE] = '{default: 1'b0};
  logic                      tbl_valid[SLOT_RANGE] = '{default: 1'b0};

  nearest_point_in_radius_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Applies one command to the table model and returns the response it yields.
  function automatic rsp_t predict_beat(input cmd_t c);
    rsp_t   r;
    longint dx, dy, dz, d2, r2, best;
    int     i;
    r = '0;
    best = 0;
    if (c.mode == MODE_LOAD) begin
      tbl_x[c.slot]     = c.coord_x;
      tbl_y[c.slot]     = c.coord_y;
      tbl_z[c.slot]     = c.coord_z;
      tbl_r[c.slot]     = c.trigger_radius;
      tbl_once[c.slot]  = c.single_use;
      tbl_used[c.slot]  = 1'b0;
      tbl_valid[c.slot] = 1'b1;
      n_loads++;
    end else if (c.mode == MODE_QUERY || c.mode == MODE_USE) begin
      n_searches++;
      for (i = 0; i < SLOT_RANGE; i++) begin
        if (!tbl_valid[i] || (tbl_once[i] && tbl_used[i])) continue;
        dx = longint'(c.coord_x) - longint'(tbl_x[i]);
        dy = longint'(c.coord_y) - longint'(tbl_y[i]);
        dz = longint'(c.coord_z) - longint'(tbl_z[i]);
        d2 = dx * dx + dy * dy + dz * dz;
        r2 = longint'(tbl_r[i]) * longint'(tbl_r[i]);
        if (d2 > r2) continue;
        // Strict compare keeps the lower slot on a tie.
        if (!r.hit || d2 < best) begin
          r.hit      = 1'b1;
          r.hit_slot = i[SLOT_W-1:0];
          best       = d2;
        end
      end
      r.hit_dist_sq = best[DIST_W-1:0];
      if (r.hit) begin
        n_hits++;
        if (c.mode == MODE_USE) begin
          if (!c.gate_open) begin
            r.gated = 1'b1;
            n_gated++;
          end else if (tbl_once[r.hit_slot]) begin
            tbl_used[r.hit_slot] = 1'b1;
          end
        end
      end
    end else begin
      n_unknown++;
    end
    return r;
  endfunction

  function automatic cmd_t make_cmd(input logic [MODE_W-1:0] mode, input int slot,
                                    input int x, input int y, input int z,
                                    input int radius, input bit once, input bit gate);
    cmd_t c;
    c.mode           = mode;
    c.slot           = slot[SLOT_W-1:0];
    c.coord_x        = x[COORD_W-1:0];
    c.coord_y        = y[COORD_W-1:0];
    c.coord_z        = z[COORD_W-1:0];
    c.trigger_radius = radius[RADIUS_W-1:0];
    c.single_use     = once;
    c.gate_open      = gate;
    return c;
  endfunction

  // Appends a command beat to the tail of the driver queue.
  function automatic void add_cmd(input cmd_t c);
    pending.insert(pending.size(), c);
  endfunction

  // Random idling, except for a calm window in the middle of the run.
  function automatic bit hold_off();
    if (n_accepted >= 250 && n_accepted < 350) return 1'b0;
    return $urandom_range(0, 99) < 33;
  endfunction

  // Command driver: the prediction is taken at the edge that accepts the beat.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_rsp.insert(expected_rsp.size(), predict_beat(cmd));
        n_accepted <= n_accepted + 1;
      end
      if (!cmd_valid || cmd_ready) begin
        if (pending.size() != 0 && !hold_off()) begin
          cmd       <= pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response beat with nothing expected: %p", rsp);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          if (rsp.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, rsp.hit);
            errors++;
          end
          if (rsp.hit_slot !== e.hit_slot) begin
            $error("hit_slot: expected %0d, got %0d", e.hit_slot, rsp.hit_slot);
            errors++;
          end
          if (rsp.hit_dist_sq !== e.hit_dist_sq) begin
            $error("hit_dist_sq: expected %0d, got %0d", e.hit_dist_sq, rsp.hit_dist_sq);
            errors++;
          end
          if (rsp.gated !== e.gated) begin
            $error("gated: expected %0d, got %0d", e.gated, rsp.gated);
            errors++;
          end
        end
      end
      rsp_ready <= !hold_off();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, expected_rsp.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int   k, sel;
    bit   wide;
    cmd_t c;

    // Directed part.
    add_cmd(make_cmd(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0));   // empty table
    add_cmd(make_cmd(MODE_LOAD, 63, 32767, 32767, 32767, 65535, 0, 0));
    add_cmd(make_cmd(MODE_LOAD, 0, -32768, -32768, -32768, 65535, 1, 0));
    add_cmd(make_cmd(MODE_QUERY, 0, -32768, -32768, -32768, 0, 0, 0));
    // Distance exactly on the radius still counts as in range.
    add_cmd(make_cmd(MODE_QUERY, 0, 32767, -32768, 32767, 0, 0, 0));
    add_cmd(make_cmd(MODE_QUERY, 0, 32767, 32767, 32767, 0, 0, 0));
    add_cmd(make_cmd(MODE_USE, 0, -32768, -32768, -32768, 0, 0, 0));  // gated
    add_cmd(make_cmd(MODE_QUERY, 0, -32768, -32768, -32768, 0, 0, 0));
    add_cmd(make_cmd(MODE_USE, 0, -32768, -32768, -32768, 0, 0, 1));  // marks used
    add_cmd(make_cmd(MODE_QUERY, 0, -32768, -32768, -32768, 0, 0, 0));
    add_cmd(make_cmd(MODE_USE, 0, -32768, -32768, -32768, 0, 0, 1));
    // Two identical points: the lower slot must win.
    add_cmd(make_cmd(MODE_LOAD, 6, 100, 0, 0, 10, 0, 0));
    add_cmd(make_cmd(MODE_LOAD, 5, 100, 0, 0, 10, 0, 0));
    add_cmd(make_cmd(MODE_LOAD, 3, 104, 0, 0, 3, 0, 0));
    add_cmd(make_cmd(MODE_QUERY, 0, 100, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(MODE_QUERY, 0, 103, 0, 0, 0, 0, 0));
    // Zero radius matches only the exact point.
    add_cmd(make_cmd(MODE_LOAD, 7, -500, 7, -9, 0, 0, 1));
    add_cmd(make_cmd(MODE_QUERY, 0, -500, 7, -9, 0, 0, 0));
    add_cmd(make_cmd(MODE_QUERY, 0, -500, 8, -9, 0, 0, 0));
    add_cmd(make_cmd(MODE_USE, 0, -500, 7, -9, 0, 0, 1));
    add_cmd(make_cmd(MODE_QUERY, 0, -500, 7, -9, 0, 0, 0));
    add_cmd(make_cmd(MODE_NONE, 21, -1, 1, 0, 65535, 1, 1));
    // Reloading a used one-shot entry makes it live again.
    add_cmd(make_cmd(MODE_LOAD, 0, -32768, -32768, -32768, 65535, 1, 0));
    add_cmd(make_cmd(MODE_QUERY, 0, -32768, -32768, -32768, 0, 0, 0));

    // Random part: mostly a tight cluster so that searches find points, with
    // some full-range beats to exercise every bit and the no-hit paths.
    for (k = 0; k < NUM_RANDOM; k++) begin
      sel  = $urandom_range(0, 99);
      wide = ($urandom_range(0, 4) == 0);
      c.mode = (sel < 40) ? MODE_LOAD : (sel < 70) ? MODE_QUERY :
               (sel < 95) ? MODE_USE : MODE_NONE;
      c.slot           = SLOT_W'($urandom_range(0, SLOT_RANGE - 1));
      c.coord_x        = wide ? COORD_W'($urandom)
                              : COORD_W'(int'($urandom_range(0, 255)) - 128);
      c.coord_y        = wide ? COORD_W'($urandom)
                              : COORD_W'(int'($urandom_range(0, 255)) - 128);
      c.coord_z        = wide ? COORD_W'($urandom)
                              : COORD_W'(int'($urandom_range(0, 255)) - 128);
      c.trigger_radius = wide ? RADIUS_W'($urandom)
                              : RADIUS_W'($urandom_range(0, 400));
      c.single_use     = 1'($urandom_range(0, 1));
      c.gate_open      = 1'($urandom_range(0, 1));
      add_cmd(c);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || cmd_valid || expected_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d beats: %0d loads, %0d searches (%0d hits, %0d gated), %0d unknown",
             n_accepted, n_loads, n_searches, n_hits, n_gated, n_unknown);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> nearest_point_in_radius_core.f
rtl/npir_pkg.sv
rtl/nearest_point_in_radius_core.sv
tb/tb_nearest_point_in_radius_core.sv
